### hw/rtl/bclr_pkg.sv
// Package: shared types and constants for the button click / long-press scanner.
`default_nettype none
package bclr_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int CNT_W       = 16;
  localparam int BIDX_W      = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd2;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST   = 16'd2;
  localparam logic [CNT_W-1:0] LONG_PRESS_RST = 16'd100;
  localparam logic [CNT_W-1:0] REPEAT_RST     = 16'd15;

  // event kinds
  localparam logic KIND_CLICK = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] repeat_ticks;
  } bclr_cfg_t;

  typedef struct packed {
    logic hit;
    logic kind;
  } bclr_evt_t;

endpackage
`default_nettype wire

### hw/rtl/bclr_in_if.sv
// Interface: input channel carrying one scan-tick word of pin levels.
`default_nettype none
interface bclr_in_if
  import bclr_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface
`default_nettype wire

### hw/rtl/bclr_out_if.sv
// Interface: result channel carrying one button event word.
`default_nettype none
interface bclr_out_if
  import bclr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BIDX_W-1:0] button_index;
  logic              event_kind;
  logic              last_event;

  modport source (output valid, output button_index, output event_kind, output last_event,
                  input ready);
  modport sink   (input valid, input button_index, input event_kind, input last_event,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/button_click_longpress_repeat.sv
// Top level: four-button scanner emitting click and long-press/repeat events.
// Events of a scan tick appear on the output in the cycle after the tick word is accepted.
// Output: one event word per cycle while out_ch.ready is high; a tick's events (at most four)
//   leave one at a time over the single event output port.
// The next tick is accepted in the same cycle its predecessor's last event is taken.
// Reset (sync, active low): counters and flags cleared, registers to 2 / 100 / 15.
`default_nettype none
module button_click_longpress_repeat
  import bclr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bclr_in_if.sink                   in_ch,
  bclr_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CNT_W-1:0]     cfg_wdata
);

  // Config regs: user writes only while idle (unenforced); lanes read them directly.
  bclr_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RST;
      cfg_r.long_press_ticks <= LONG_PRESS_RST;
      cfg_r.repeat_ticks     <= REPEAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DEBOUNCE:   cfg_r.debounce_ticks   <= cfg_wdata;
        REG_LONG_PRESS: cfg_r.long_press_ticks <= cfg_wdata;
        REG_REPEAT:     cfg_r.repeat_ticks     <= cfg_wdata;
        default:        ; // unmapped index: write dropped
      endcase
    end
  end

  // A tick word is taken when the merge stage can load a fresh event set.
  logic      load_ok;
  logic      step;
  bclr_evt_t evts [NUM_BUTTONS];

  assign in_ch.ready = load_ok;
  assign step        = in_ch.valid && load_ok;

  // One lane per button; pins are active low.
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    bclr_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (step),
      .pressed (!in_ch.pin_levels[g]),
      .cfg     (cfg_r),
      .evt     (evts[g])
    );
  end

  // Merge: registers the lane hits and pops them lowest button first.
  bclr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .evts      (evts),
    .load_ok   (load_ok),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_index (out_ch.button_index),
    .out_kind  (out_ch.event_kind),
    .out_last  (out_ch.last_event)
  );

endmodule
`default_nettype wire

### hw/rtl/bclr_lane.sv
// Module: per-button lane holding the press counter and long-press flag.
`default_nettype none
module bclr_lane
  import bclr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  wire logic      pressed,
  input  wire bclr_cfg_t cfg,
  output bclr_evt_t      evt
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             long_r, long_nxt;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] reload;

  always_comb begin
    cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
    reload  = (cfg.repeat_ticks > cfg.long_press_ticks) ? '0
            : cfg.long_press_ticks - cfg.repeat_ticks;
    evt      = '{hit: 1'b0, kind: KIND_CLICK};
    cnt_nxt  = '0;
    long_nxt = 1'b0;
    if (pressed) begin
      cnt_nxt  = cnt_inc;
      long_nxt = long_r;
      if (cnt_inc >= cfg.long_press_ticks) begin
        evt      = '{hit: 1'b1, kind: KIND_LONG};
        long_nxt = 1'b1;
        cnt_nxt  = reload;
      end
    end else if (cnt_r >= cfg.debounce_ticks && !long_r) begin
      evt = '{hit: 1'b1, kind: KIND_CLICK};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      long_r <= 1'b0;
    end else if (step) begin
      cnt_r  <= cnt_nxt;
      long_r <= long_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bclr_merge.sv
// Module: merges lane events and serializes them in button order.
`default_nettype none
module bclr_merge
  import bclr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire bclr_evt_t         evts [NUM_BUTTONS],
  output logic                   load_ok,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [BIDX_W-1:0]      out_index,
  output logic                   out_kind,
  output logic                   out_last
);

  logic [NUM_BUTTONS-1:0] mask_r, mask_nxt;
  logic [NUM_BUTTONS-1:0] kind_r;
  logic [NUM_BUTTONS-1:0] sel_oh;
  logic [NUM_BUTTONS-1:0] rest;
  logic [NUM_BUTTONS-1:0] hits, kinds;

  always_comb begin
    out_index = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (mask_r[i]) out_index = BIDX_W'(i);
    end
    sel_oh    = NUM_BUTTONS'(1) << out_index;
    rest      = mask_r & ~sel_oh;
    out_valid = |mask_r;
    out_kind  = kind_r[out_index];
    out_last  = (rest == '0);
    // free now, or the last pending word leaves this cycle
    load_ok   = !out_valid || (out_last && out_ready);
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hits[i]  = evts[i].hit;
      kinds[i] = evts[i].kind;
    end
    mask_nxt = mask_r;
    if (load)
      mask_nxt = hits;
    else if (out_valid && out_ready)
      mask_nxt = rest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kinds;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bclr_chk.sv
// Checker: port-level assertions for the scanner, bound to the top level.
`default_nettype none
module bclr_chk
  import bclr_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BIDX_W-1:0] out_index,
  input wire logic              out_kind,
  input wire logic              out_last
);

  // nothing pending right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("event word pending after reset");

  // a stalled event word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_kind)
                                && $stable(out_last))
    else $error("stalled event word changed");

  // no new tick while a burst still has words after the current one
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("tick accepted mid-burst");

  // a tick taken while words are pending only when the last one leaves
  a_swap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid |-> out_last && out_ready)
    else $error("tick accepted over pending events");

  // within a burst, buttons come out in rising order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && (out_index > $past(out_index)))
    else $error("events out of button order");

endmodule

bind button_click_longpress_repeat bclr_chk u_bclr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.button_index),
  .out_kind  (out_ch.event_kind),
  .out_last  (out_ch.last_event)
);
`default_nettype wire
